>>> src/assert_macros.svh
// Assertion macros shared by the list editor RTL.
// Each macro checks on the rising edge of clk and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ple_pkg.sv
// Shared types and constants for the positional list editor.
// Used by ple_cell, ple_select and positional_list_editor; depends on nothing.
package ple_pkg;

    localparam int LIST_DEPTH  = 256;
    localparam int POINT_RANGE = 256;
    localparam int MIN_COUNT   = 2;

    localparam int POS_W   = 8;
    localparam int VAL_W   = 8;
    localparam int IDX_W   = $clog2(LIST_DEPTH);
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int GROUP_SIZE = 16;
    localparam int GRP_LO_W   = $clog2(GROUP_SIZE);
    localparam int NUM_GROUPS = (LIST_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic [1:0] {
        KIND_REPLACE = 2'd0,
        KIND_INSERT  = 2'd1,
        KIND_REMOVE  = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_MIN   = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
        logic [VAL_W-1:0]   val;
    } cell_ctl_t;

endpackage

>>> src/ple_cell.sv
// One storage cell of the list: holds a single entry and trades it with its neighbors.
// Depends on ple_pkg for the control struct and widths.
module ple_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ple_pkg::cell_ctl_t        ctl,
    input  logic [ple_pkg::IDX_W-1:0] index,
    input  logic [ple_pkg::VAL_W-1:0] left,
    input  logic [ple_pkg::VAL_W-1:0] right,
    output logic [ple_pkg::VAL_W-1:0] value
);

    logic [ple_pkg::VAL_W-1:0] value_reg;
    logic [ple_pkg::VAL_W-1:0] value_next;
    logic [ple_pkg::CMP_W-1:0] my_idx;
    logic [ple_pkg::CMP_W-1:0] tgt_idx;

    assign my_idx  = ple_pkg::CMP_W'(index);
    assign tgt_idx = ple_pkg::CMP_W'(ctl.pos);

    always_comb
    begin
        value_next = value_reg;
        case (ctl.op)
            ple_pkg::CELL_WRITE:
            begin
                if (my_idx == tgt_idx)
                begin
                    value_next = ctl.val;
                end
            end
            ple_pkg::CELL_INSERT:
            begin
                if (my_idx == tgt_idx)
                begin
                    value_next = ctl.val;
                end
                else if (my_idx > tgt_idx)
                begin
                    value_next = left;
                end
            end
            ple_pkg::CELL_REMOVE:
            begin
                if (my_idx >= tgt_idx)
                begin
                    value_next = right;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

>>> src/ple_select.sv
// Two-stage registered selection tree that picks the entry at a position out of all cells.
// Depends on ple_pkg for the group size and widths.
module ple_select
(
    input  logic                                         clk,
    input  logic [ple_pkg::LIST_DEPTH-1:0][ple_pkg::VAL_W-1:0] cells,
    input  logic [ple_pkg::POS_W-1:0]                    pos,
    output logic [ple_pkg::VAL_W-1:0]                    entry
);

    logic [ple_pkg::NUM_GROUPS-1:0][ple_pkg::VAL_W-1:0] grp_reg;
    logic [ple_pkg::NUM_GROUPS-1:0][ple_pkg::VAL_W-1:0] grp_next;
    logic [ple_pkg::VAL_W-1:0]                          pick_reg;
    logic [ple_pkg::VAL_W-1:0]                          pick_next;
    logic [ple_pkg::GRP_LO_W-1:0]                       lo;
    logic [ple_pkg::POS_W-1:0]                          hi;

    assign lo = pos[ple_pkg::GRP_LO_W-1:0];
    assign hi = pos >> ple_pkg::GRP_LO_W;

    always_comb
    begin
        grp_next = '0;
        for (int g = 0; g < ple_pkg::NUM_GROUPS; g++)
        begin
            for (int k = 0; k < ple_pkg::GROUP_SIZE; k++)
            begin
                if ((k == int'(lo)) && (g * ple_pkg::GROUP_SIZE + k < ple_pkg::LIST_DEPTH))
                begin
                    grp_next[g] = cells[g * ple_pkg::GROUP_SIZE + k];
                end
            end
        end
    end

    always_comb
    begin
        pick_next = '0;
        for (int g = 0; g < ple_pkg::NUM_GROUPS; g++)
        begin
            if (g == int'(hi))
            begin
                pick_next = grp_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg  <= grp_next;
        pick_reg <= pick_next;
    end

    assign entry = pick_reg;

endmodule

>>> src/positional_list_editor.sv
// Top level of the positional list editor: request decode, entry count and the cell row.
// Depends on ple_pkg, ple_cell, ple_select and assert_macros.svh.
//
//  Channel   Direction  Carries
//  s_axis    in         tuser: kind; tdata: position, point_value
//  m_axis    out        tuser: status; tdata: live_count, entry_at_position
//
// A request passes through the states: the edit lands in every cell at the accepting
// edge, the two-stage selection tree then fetches the entry through its group and pick
// registers, and the result is held in the output register until it is taken. One
// request is in flight at a time. Reset clears every cell to zero and the count to two;
// the block is ready at once. A stalled output holds its data and blocks new requests.
`include "assert_macros.svh"

module positional_list_editor
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] position, [15:8] point_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [8:0] live_count, [16:9] entry_at_position, zero fill
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_PICK,
        S_OUT
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [ple_pkg::CNT_W-1:0]      count_reg;
    logic [ple_pkg::CNT_W-1:0]      count_next;
    ple_pkg::status_t               status_reg;
    ple_pkg::status_t               status_next;
    logic [ple_pkg::POS_W-1:0]      pos_reg;
    logic [ple_pkg::POS_W-1:0]      pos_next;

    logic                           accept;
    ple_pkg::kind_t                 kind;
    logic [ple_pkg::POS_W-1:0]      position;
    logic [ple_pkg::VAL_W-1:0]      point_value;
    logic [ple_pkg::CMP_W-1:0]      pos_ext;
    logic [ple_pkg::CMP_W-1:0]      cnt_ext;
    logic                           val_ok;
    ple_pkg::cell_ctl_t             ctl;

    logic [ple_pkg::LIST_DEPTH-1:0][ple_pkg::VAL_W-1:0] cell_val;
    logic [ple_pkg::VAL_W-1:0]      sel_entry;
    logic                           beyond;
    logic [ple_pkg::VAL_W-1:0]      entry_at_position;

    assign kind        = ple_pkg::kind_t'(s_axis_tuser);
    assign position    = s_axis_tdata[ple_pkg::POS_W-1:0];
    assign point_value = s_axis_tdata[ple_pkg::POS_W+ple_pkg::VAL_W-1:ple_pkg::POS_W];
    assign pos_ext     = ple_pkg::CMP_W'(position);
    assign cnt_ext     = ple_pkg::CMP_W'(count_reg);
    assign val_ok      = int'(point_value) < ple_pkg::POINT_RANGE;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        status_next = ple_pkg::ST_OK;
        case (kind)
            ple_pkg::KIND_REPLACE:
            begin
                if (pos_ext >= cnt_ext || !val_ok)
                begin
                    status_next = ple_pkg::ST_RANGE;
                end
            end
            ple_pkg::KIND_INSERT:
            begin
                if (count_reg >= ple_pkg::CNT_W'(ple_pkg::LIST_DEPTH))
                begin
                    status_next = ple_pkg::ST_FULL;
                end
                else if (pos_ext > cnt_ext || !val_ok)
                begin
                    status_next = ple_pkg::ST_RANGE;
                end
            end
            ple_pkg::KIND_REMOVE:
            begin
                if (count_reg <= ple_pkg::CNT_W'(ple_pkg::MIN_COUNT))
                begin
                    status_next = ple_pkg::ST_MIN;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status_next = ple_pkg::ST_RANGE;
                end
            end
            default:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = ple_pkg::ST_RANGE;
                end
            end
        endcase
    end

    always_comb
    begin
        ctl.op  = ple_pkg::CELL_HOLD;
        ctl.pos = position;
        ctl.val = point_value;
        count_next = count_reg;
        if (accept && status_next == ple_pkg::ST_OK)
        begin
            case (kind)
                ple_pkg::KIND_REPLACE:
                begin
                    ctl.op = ple_pkg::CELL_WRITE;
                end
                ple_pkg::KIND_INSERT:
                begin
                    ctl.op     = ple_pkg::CELL_INSERT;
                    count_next = count_reg + ple_pkg::CNT_W'(1);
                end
                ple_pkg::KIND_REMOVE:
                begin
                    ctl.op     = ple_pkg::CELL_REMOVE;
                    count_next = count_reg - ple_pkg::CNT_W'(1);
                end
                default:
                begin
                    ctl.op = ple_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_GROUP;
                    pos_next   = position;
                end
            end
            S_GROUP:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= ple_pkg::CNT_W'(ple_pkg::MIN_COUNT);
            status_reg <= ple_pkg::ST_OK;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            if (accept)
            begin
                status_reg <= status_next;
            end
        end
    end

    for (genvar i = 0; i < ple_pkg::LIST_DEPTH; i++)
    begin : g_cell
        logic [ple_pkg::VAL_W-1:0] left_val;
        logic [ple_pkg::VAL_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_left
            assign left_val = cell_val[i-1];
        end

        if (i == ple_pkg::LIST_DEPTH - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_right
            assign right_val = cell_val[i+1];
        end

        ple_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .index (ple_pkg::IDX_W'(i)),
            .left  (left_val),
            .right (right_val),
            .value (cell_val[i])
        );
    end

    ple_select u_select
    (
        .clk   (clk),
        .cells (cell_val),
        .pos   (pos_reg),
        .entry (sel_entry)
    );

    assign beyond            = ple_pkg::CMP_W'(pos_reg) >= ple_pkg::CMP_W'(count_reg);
    assign entry_at_position = beyond ? '0 : sel_entry;

    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {7'd0, entry_at_position, 9'(count_reg)};

    `ASSERT_ALWAYS(a_count_range,
        (count_reg >= ple_pkg::CNT_W'(ple_pkg::MIN_COUNT))
        && (count_reg <= ple_pkg::CNT_W'(ple_pkg::LIST_DEPTH)),
        "entry count left its legal range")

    `ASSERT_ALWAYS(a_one_in_flight, !(s_axis_tready && m_axis_tvalid),
        "input ready while a result is pending")

    `ASSERT_NEXT(a_insert_grows,
        accept && kind == ple_pkg::KIND_INSERT && status_next == ple_pkg::ST_OK,
        count_reg == $past(count_reg) + ple_pkg::CNT_W'(1),
        "accepted insert did not grow the count")

    `ASSERT_NEXT(a_reject_holds,
        accept && status_next != ple_pkg::ST_OK,
        $stable(count_reg),
        "rejected request changed the count")

    `ASSERT_NEXT(a_accept_busy, accept, !s_axis_tready && !m_axis_tvalid,
        "request did not enter the selection stages")

endmodule

>>> dv/positional_list_editor_tb.sv
// Self-checking testbench for positional_list_editor: directed edits, fill to capacity,
// drain to minimum and random edit mixes, each result checked against a shadow list.
// Depends on ple_pkg and the positional_list_editor RTL.
module positional_list_editor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PCT    = 37;
    localparam int SETTLE      = 8;

    typedef struct packed {
        ple_pkg::status_t status;
        logic [8:0]       count;
        logic [7:0]       entry;
    } edit_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic [ple_pkg::VAL_W-1:0] shadow_entries [0:ple_pkg::LIST_DEPTH-1];
    int                        shadow_count;
    edit_result_t              pending_results [$];
    int                        error_count = 0;
    int                        stall_cycles = 0;
    bit                        no_idle = 1'b0;

    positional_list_editor uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic edit_result_t apply_edit(ple_pkg::kind_t kind,
                                                logic [ple_pkg::POS_W-1:0] pos,
                                                logic [ple_pkg::VAL_W-1:0] val);
        edit_result_t res;
        bit           val_ok;
        int           p;
        int           i;
        p      = int'(pos);
        val_ok = int'(val) < ple_pkg::POINT_RANGE;
        res.status = ple_pkg::ST_OK;
        case (kind)
            ple_pkg::KIND_REPLACE:
            begin
                if (p >= shadow_count || !val_ok)
                    res.status = ple_pkg::ST_RANGE;
                else
                    shadow_entries[p] = val;
            end
            ple_pkg::KIND_INSERT:
            begin
                if (shadow_count >= ple_pkg::LIST_DEPTH)
                    res.status = ple_pkg::ST_FULL;
                else if (p > shadow_count || !val_ok)
                    res.status = ple_pkg::ST_RANGE;
                else
                begin
                    for (i = shadow_count; i > p; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[p] = val;
                    shadow_count++;
                end
            end
            ple_pkg::KIND_REMOVE:
            begin
                if (shadow_count <= ple_pkg::MIN_COUNT)
                    res.status = ple_pkg::ST_MIN;
                else if (p >= shadow_count)
                    res.status = ple_pkg::ST_RANGE;
                else
                begin
                    for (i = p + 1; i < shadow_count; i++)
                        shadow_entries[i-1] = shadow_entries[i];
                    shadow_count--;
                end
            end
            default:
            begin
                if (p >= shadow_count)
                    res.status = ple_pkg::ST_RANGE;
            end
        endcase
        res.count = shadow_count[8:0];
        res.entry = (p < shadow_count) ? shadow_entries[p] : '0;
        return res;
    endfunction

    task automatic send_request(ple_pkg::kind_t kind, int pos, int val);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {val[7:0], pos[7:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(apply_edit(kind, pos[7:0], val[7:0]));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        edit_result_t want;
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no request or result accepted for %0d cycles",
                         $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual status %0d",
                             $time, m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[8:0] !== want.count)
                    begin
                        $display("%0t: live_count mismatch: expected %0d, actual %0d",
                                 $time, want.count, m_axis_tdata[8:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[16:9] !== want.entry)
                    begin
                        $display("%0t: entry mismatch: expected %0d, actual %0d",
                                 $time, want.entry, m_axis_tdata[16:9]);
                        error_count++;
                    end
                    if (m_axis_tdata[23:17] !== 7'd0)
                    begin
                        $display("%0t: fill bits mismatch: expected 0, actual %0h",
                                 $time, m_axis_tdata[23:17]);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic test_reset_state();
        send_request(ple_pkg::KIND_READ, 0, 8'hFF);
        send_request(ple_pkg::KIND_READ, 1, 8'h00);
        send_request(ple_pkg::KIND_READ, 2, 8'h00);
        send_request(ple_pkg::KIND_READ, 255, 8'hFF);
        send_request(ple_pkg::KIND_REMOVE, 0, 8'h00);
        send_request(ple_pkg::KIND_REMOVE, 255, 8'hFF);
        send_request(ple_pkg::KIND_REPLACE, 2, 8'h11);
        send_request(ple_pkg::KIND_REPLACE, 255, 8'hFF);
        send_request(ple_pkg::KIND_REPLACE, 0, 8'hFF);
        send_request(ple_pkg::KIND_REPLACE, 1, 8'h00);
        send_request(ple_pkg::KIND_INSERT, 3, 8'h22);
        send_request(ple_pkg::KIND_INSERT, 255, 8'hFF);
        send_request(ple_pkg::KIND_INSERT, 2, 8'hA5);
        send_request(ple_pkg::KIND_INSERT, 0, 8'h5A);
        send_request(ple_pkg::KIND_READ, 3, 8'h00);
        send_request(ple_pkg::KIND_REMOVE, 4, 8'h00);
        send_request(ple_pkg::KIND_REMOVE, 3, 8'h00);
        send_request(ple_pkg::KIND_REMOVE, 0, 8'h00);
        send_request(ple_pkg::KIND_READ, 0, 8'h00);
        send_request(ple_pkg::KIND_READ, 1, 8'h00);
        drain_results();
    endtask

    task automatic test_fill_to_capacity();
        while (shadow_count < ple_pkg::LIST_DEPTH)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(ple_pkg::KIND_READ, $urandom_range(0, shadow_count - 1),
                             $urandom_range(0, 255));
            else
                send_request(ple_pkg::KIND_INSERT, $urandom_range(0, shadow_count),
                             $urandom_range(0, 255));
        end
        send_request(ple_pkg::KIND_INSERT, 0, 8'hFF);
        send_request(ple_pkg::KIND_INSERT, 255, 8'h00);
        send_request(ple_pkg::KIND_READ, 255, 8'h00);
        send_request(ple_pkg::KIND_REPLACE, 255, $urandom_range(0, 255));
        send_request(ple_pkg::KIND_READ, 128, 8'h00);
        send_request(ple_pkg::KIND_REMOVE, 255, 8'h00);
        send_request(ple_pkg::KIND_READ, 255, 8'h00);
        send_request(ple_pkg::KIND_INSERT, 255, 8'hC3);
        send_request(ple_pkg::KIND_READ, 255, 8'h00);
        drain_results();
    endtask

    task automatic test_drain_to_minimum();
        while (shadow_count > ple_pkg::MIN_COUNT)
        begin
            case ($urandom_range(0, 9))
                0: send_request(ple_pkg::KIND_READ, $urandom_range(0, shadow_count - 1), 0);
                1: send_request(ple_pkg::KIND_REPLACE, $urandom_range(0, shadow_count - 1),
                                $urandom_range(0, 255));
                default: send_request(ple_pkg::KIND_REMOVE,
                                      $urandom_range(0, shadow_count - 1), 0);
            endcase
        end
        send_request(ple_pkg::KIND_REMOVE, 1, 0);
        send_request(ple_pkg::KIND_READ, 1, 0);
        drain_results();
    endtask

    task automatic random_edit(int insert_pct, int remove_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 15)
            send_request(ple_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                         $urandom_range(0, 255));
        else if (roll < insert_pct)
            send_request(ple_pkg::KIND_INSERT, $urandom_range(0, shadow_count),
                         $urandom_range(0, 255));
        else if (roll < insert_pct + remove_pct)
            send_request(ple_pkg::KIND_REMOVE, $urandom_range(0, shadow_count - 1), 0);
        else if (roll < insert_pct + remove_pct + (100 - insert_pct - remove_pct) / 2)
            send_request(ple_pkg::KIND_REPLACE, $urandom_range(0, shadow_count - 1),
                         $urandom_range(0, 255));
        else
            send_request(ple_pkg::KIND_READ, $urandom_range(0, shadow_count - 1),
                         $urandom_range(0, 255));
    endtask

    task automatic test_random_mix();
        int n;
        for (n = 0; n < 650; n++)
            random_edit(45, 15);
        no_idle = 1'b1;
        for (n = 0; n < 300; n++)
            random_edit(30, 30);
        no_idle = 1'b0;
        drain_results();
        for (n = 0; n < 350; n++)
            random_edit(15, 45);
        drain_results();
    endtask

    initial
    begin
        int i;
        for (i = 0; i < ple_pkg::LIST_DEPTH; i++)
            shadow_entries[i] = '0;
        shadow_count = ple_pkg::MIN_COUNT;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_fill_to_capacity();
        test_drain_to_minimum();
        test_random_mix();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
